>>> sv/dual_sensor_level_alarm_with_blink_unit_macros.svh
// Assertion macros shared by the checker of the dual sensor level alarm.
// Each macro expands to one labeled concurrent assertion on clk, disabled in reset.
`ifndef DUAL_SENSOR_LEVEL_ALARM_WITH_BLINK_UNIT_MACROS_SVH
`define DUAL_SENSOR_LEVEL_ALARM_WITH_BLINK_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSLA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dsla_pkg.sv
// Shared types, codes and constants of the dual sensor level alarm.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dsla_pkg;

  localparam int READING_BITS   = 12;
  localparam int CFG_INDEX_BITS = 3;
  localparam int LEVEL_BITS     = 2;
  localparam int REASON_BITS    = 4;
  localparam int COLOUR_BITS    = 2;
  localparam int LAMP_BITS      = 8;

  localparam logic [31:0] WARN_BLINK_MS  = 32'd500;
  localparam logic [31:0] ALARM_BLINK_MS = 32'd250;
  localparam logic [LAMP_BITS-1:0] LAMP_ON  = 8'd100;
  localparam logic [LAMP_BITS-1:0] LAMP_OFF = 8'd0;

  // Alarm levels.
  localparam logic [LEVEL_BITS-1:0] LVL_NORMAL = 2'd0;
  localparam logic [LEVEL_BITS-1:0] LVL_WARN   = 2'd1;
  localparam logic [LEVEL_BITS-1:0] LVL_ALARM  = 2'd2;

  // Lamp colours.
  localparam logic [COLOUR_BITS-1:0] COL_OFF    = 2'd0;
  localparam logic [COLOUR_BITS-1:0] COL_GREEN  = 2'd1;
  localparam logic [COLOUR_BITS-1:0] COL_YELLOW = 2'd2;
  localparam logic [COLOUR_BITS-1:0] COL_RED    = 2'd3;

  // Reason codes.
  localparam logic [REASON_BITS-1:0] RSN_NONE        = 4'd0;
  localparam logic [REASON_BITS-1:0] RSN_INVALID     = 4'd1;
  localparam logic [REASON_BITS-1:0] RSN_LOW_ALARM   = 4'd2;
  localparam logic [REASON_BITS-1:0] RSN_HIGH_ALARM  = 4'd3;
  localparam logic [REASON_BITS-1:0] RSN_LOW_WARN    = 4'd4;
  localparam logic [REASON_BITS-1:0] RSN_HIGH_WARN   = 4'd5;
  localparam logic [REASON_BITS-1:0] RSN_DISAGREE    = 4'd6;
  localparam logic [REASON_BITS-1:0] RSN_SECOND_FAIL = 4'd7;
  localparam logic [REASON_BITS-1:0] RSN_FIRST_FAIL  = 4'd8;
  localparam logic [REASON_BITS-1:0] RSN_ACT1_FAIL   = 4'd9;
  localparam logic [REASON_BITS-1:0] RSN_ACT2_FAIL   = 4'd10;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_ALARM     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_WARNING   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_WARNING  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_ALARM    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DISAGREE      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SINGLE_MODE   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_SENSOR = 3'd6;

  typedef logic [READING_BITS-1:0] mbar_t;

  typedef struct packed {
    mbar_t low_alarm;
    mbar_t low_warning;
    mbar_t high_warning;
    mbar_t high_alarm;
    mbar_t disagree;
    logic  single_mode;
    logic  active_sensor;
  } cfg_t;

  // Level found for one item, and the reason code it writes, if any.
  typedef struct packed {
    logic [LEVEL_BITS-1:0]  level;
    logic                   reason_wr;
    logic [REASON_BITS-1:0] reason;
  } eval_t;

  // Grade of one reading; reason_wr is set whenever the grade is not normal.
  function automatic eval_t grade(input mbar_t mbar, input cfg_t cfg);
    eval_t g;
    g.level     = LVL_NORMAL;
    g.reason_wr = 1'b1;
    g.reason    = RSN_NONE;
    if (mbar < cfg.low_alarm) begin
      g.level  = LVL_ALARM;
      g.reason = RSN_LOW_ALARM;
    end else if (mbar > cfg.high_alarm) begin
      g.level  = LVL_ALARM;
      g.reason = RSN_HIGH_ALARM;
    end else if (mbar < cfg.low_warning) begin
      g.level  = LVL_WARN;
      g.reason = RSN_LOW_WARN;
    end else if (mbar > cfg.high_warning) begin
      g.level  = LVL_WARN;
      g.reason = RSN_HIGH_WARN;
    end else begin
      g.reason_wr = 1'b0;
    end
    return g;
  endfunction

endpackage

>>> sv/dual_sensor_level_alarm_with_blink_unit.sv
// An accepted item enters the input register, and its result is written to the output
// register when the item moves on, which it cannot do while a result waits to be taken.
// Throughput: one item per cycle; while a result waits to be taken, one more item can
// wait in the input register before in_ready drops.
// Reset (rst, synchronous) loads the default limits, dual mode, normal level, green lamp.
// Depends on dsla_pkg and dsla_eval.
`timescale 1ns / 1ps

module dual_sensor_level_alarm_with_blink_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [31:0]                            now_ms,
  input  logic                                   data_valid,
  input  logic                                   first_valid,
  input  logic                                   second_valid,
  input  logic [dsla_pkg::READING_BITS-1:0]      first_mbar,
  input  logic [dsla_pkg::READING_BITS-1:0]      second_mbar,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [dsla_pkg::LEVEL_BITS-1:0]        level,
  output logic [dsla_pkg::REASON_BITS-1:0]       reason,
  output logic [dsla_pkg::COLOUR_BITS-1:0]       lamp_colour,
  output logic [dsla_pkg::LAMP_BITS-1:0]         lamp_red,
  output logic [dsla_pkg::LAMP_BITS-1:0]         lamp_green,
  output logic [dsla_pkg::LAMP_BITS-1:0]         lamp_blue,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dsla_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [dsla_pkg::READING_BITS-1:0]      cfg_data
);
  import dsla_pkg::*;

  cfg_t                    cfg;

  // Input register.
  logic                    in_reg_full;
  logic [31:0]             s1_now;
  logic                    s1_data_valid;
  logic                    s1_first_valid;
  logic                    s1_second_valid;
  mbar_t                   s1_first_mbar;
  mbar_t                   s1_second_mbar;

  // Alarm state.
  logic [LEVEL_BITS-1:0]   current_level;
  logic                    blink_phase_on;
  logic [31:0]             last_toggle_ms;
  logic [REASON_BITS-1:0]  reason_code;
  logic [COLOUR_BITS-1:0]  shown_colour;

  logic                    blink_phase_on_next;
  logic [31:0]             last_toggle_ms_next;
  logic [REASON_BITS-1:0]  reason_code_next;
  logic [COLOUR_BITS-1:0]  shown_colour_next;

  eval_t                   ev;
  logic                    move;
  logic                    changed;
  logic                    phase_mid;
  logic [REASON_BITS-1:0]  reason_mid;
  logic [31:0]             elapsed;
  logic [31:0]             period;
  logic [COLOUR_BITS-1:0]  on_colour;

  assign move      = in_reg_full && (!out_valid || out_ready);
  assign in_ready  = !in_reg_full || move;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_alarm     <= 12'd100;
      cfg.low_warning   <= 12'd160;
      cfg.high_warning  <= 12'd1400;
      cfg.high_alarm    <= 12'd1600;
      cfg.disagree      <= 12'd200;
      cfg.single_mode   <= 1'b0;
      cfg.active_sensor <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOW_ALARM:     cfg.low_alarm     <= cfg_data;
        REG_LOW_WARNING:   cfg.low_warning   <= cfg_data;
        REG_HIGH_WARNING:  cfg.high_warning  <= cfg_data;
        REG_HIGH_ALARM:    cfg.high_alarm    <= cfg_data;
        REG_DISAGREE:      cfg.disagree      <= cfg_data;
        REG_SINGLE_MODE:   cfg.single_mode   <= cfg_data[0];
        REG_ACTIVE_SENSOR: cfg.active_sensor <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_full <= 1'b0;
    end else if (in_ready) begin
      in_reg_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_now          <= now_ms;
      s1_data_valid   <= data_valid;
      s1_first_valid  <= first_valid;
      s1_second_valid <= second_valid;
      s1_first_mbar   <= first_mbar;
      s1_second_mbar  <= second_mbar;
    end
  end

  dsla_eval u_eval (
    .cfg          (cfg),
    .data_valid   (s1_data_valid),
    .first_valid  (s1_first_valid),
    .second_valid (s1_second_valid),
    .first_mbar   (s1_first_mbar),
    .second_mbar  (s1_second_mbar),
    .result       (ev)
  );

  assign changed    = (ev.level != current_level);
  assign phase_mid  = changed ? 1'b0 : blink_phase_on;
  assign reason_mid = ev.reason_wr ? ev.reason : reason_code;
  assign elapsed    = s1_now - last_toggle_ms;
  assign period     = (ev.level == LVL_WARN) ? WARN_BLINK_MS : ALARM_BLINK_MS;
  assign on_colour  = (ev.level == LVL_WARN) ? COL_YELLOW : COL_RED;

  always_comb begin
    reason_code_next    = (changed && (ev.level == LVL_NORMAL)) ? RSN_NONE : reason_mid;
    blink_phase_on_next = phase_mid;
    last_toggle_ms_next = last_toggle_ms;
    shown_colour_next   = shown_colour;
    if (ev.level == LVL_NORMAL) begin
      shown_colour_next = COL_GREEN;
    end else if (elapsed >= period) begin
      blink_phase_on_next = !phase_mid;
      last_toggle_ms_next = s1_now;
      shown_colour_next   = phase_mid ? COL_OFF : on_colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level  <= LVL_NORMAL;
      blink_phase_on <= 1'b0;
      last_toggle_ms <= '0;
      reason_code    <= RSN_NONE;
      shown_colour   <= COL_GREEN;
    end else if (move) begin
      current_level  <= ev.level;
      blink_phase_on <= blink_phase_on_next;
      last_toggle_ms <= last_toggle_ms_next;
      reason_code    <= reason_code_next;
      shown_colour   <= shown_colour_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      level       <= ev.level;
      reason      <= reason_code_next;
      lamp_colour <= shown_colour_next;
      lamp_red    <= ((shown_colour_next == COL_YELLOW) || (shown_colour_next == COL_RED))
                     ? LAMP_ON : LAMP_OFF;
      lamp_green  <= ((shown_colour_next == COL_GREEN) || (shown_colour_next == COL_YELLOW))
                     ? LAMP_ON : LAMP_OFF;
    end
  end

  assign lamp_blue = LAMP_OFF;

endmodule

>>> sv/dsla_eval.sv
// Level and reason evaluation for one item of the dual sensor level alarm.
// Purely combinational; depends on dsla_pkg.
`timescale 1ns / 1ps

module dsla_eval (
  input  dsla_pkg::cfg_t  cfg,
  input  logic            data_valid,
  input  logic            first_valid,
  input  logic            second_valid,
  input  dsla_pkg::mbar_t first_mbar,
  input  dsla_pkg::mbar_t second_mbar,
  output dsla_pkg::eval_t result
);
  import dsla_pkg::*;

  eval_t           g1;
  eval_t           g2;
  mbar_t           diff;
  logic            act_ok;

  assign g1     = grade(first_mbar, cfg);
  assign g2     = grade(second_mbar, cfg);
  assign diff   = (first_mbar > second_mbar) ? (first_mbar - second_mbar)
                                             : (second_mbar - first_mbar);
  assign act_ok = cfg.active_sensor ? second_valid : first_valid;

  // Reason writes follow the fixed order of the checks; the last one wins.
  always_comb begin
    result.level     = LVL_NORMAL;
    result.reason_wr = 1'b0;
    result.reason    = RSN_NONE;
    if (!data_valid) begin
      result.level     = LVL_WARN;
      result.reason_wr = 1'b1;
      result.reason    = RSN_INVALID;
    end else begin
      if (first_valid && g1.reason_wr) begin
        result.level     = g1.level;
        result.reason_wr = 1'b1;
        result.reason    = g1.reason;
      end
      if (second_valid && g2.reason_wr) begin
        if (g2.level > result.level) begin
          result.level = g2.level;
        end
        result.reason_wr = 1'b1;
        result.reason    = g2.reason;
      end
      if (!cfg.single_mode) begin
        if (first_valid && second_valid && (diff > cfg.disagree)) begin
          if (result.level < LVL_WARN) begin
            result.level = LVL_WARN;
          end
          result.reason_wr = 1'b1;
          result.reason    = RSN_DISAGREE;
        end
        if (first_valid != second_valid) begin
          if (result.level < LVL_WARN) begin
            result.level = LVL_WARN;
          end
          result.reason_wr = 1'b1;
          result.reason    = first_valid ? RSN_SECOND_FAIL : RSN_FIRST_FAIL;
        end
      end else if (!act_ok) begin
        if (result.level < LVL_WARN) begin
          result.level = LVL_WARN;
        end
        result.reason_wr = 1'b1;
        result.reason    = cfg.active_sensor ? RSN_ACT2_FAIL : RSN_ACT1_FAIL;
      end
    end
  end

endmodule

>>> sv/dsla_checker.sv
// Port-level checker for the dual sensor level alarm, bound to the top level.
// Depends on dsla_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "dual_sensor_level_alarm_with_blink_unit_macros.svh"

module dsla_port_props (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [dsla_pkg::LEVEL_BITS-1:0]     level,
  input logic [dsla_pkg::REASON_BITS-1:0]    reason,
  input logic [dsla_pkg::COLOUR_BITS-1:0]    lamp_colour,
  input logic [dsla_pkg::LAMP_BITS-1:0]      lamp_red,
  input logic [dsla_pkg::LAMP_BITS-1:0]      lamp_green,
  input logic [dsla_pkg::LAMP_BITS-1:0]      lamp_blue
);
  import dsla_pkg::*;

  logic [LEVEL_BITS+REASON_BITS+COLOUR_BITS+3*LAMP_BITS-1:0] status;
  logic stalled;
  logic is_normal;
  logic has_reason;
  logic normal_shown;
  logic green_want;
  logic red_want;
  logic rgb_ok;

  assign status       = {level, reason, lamp_colour, lamp_red, lamp_green, lamp_blue};
  assign stalled      = out_valid && !out_ready;
  assign is_normal    = (level == LVL_NORMAL);
  assign has_reason   = (reason != RSN_NONE);
  assign normal_shown = (lamp_colour == COL_GREEN) && (reason == RSN_NONE);
  assign green_want   = (lamp_colour == COL_GREEN) || (lamp_colour == COL_YELLOW);
  assign red_want     = (lamp_colour == COL_YELLOW) || (lamp_colour == COL_RED);
  assign rgb_ok       = (lamp_blue == LAMP_OFF) && ((lamp_green == LAMP_ON) == green_want)
                        && ((lamp_red == LAMP_ON) == red_want);

  // A result that is not taken stays on the ports unchanged.
  `DSLA_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(status), "stalled result changed")

  // Normal level always shows green with the reason cleared.
  `DSLA_ASSERT_SAME(a_normal_green, out_valid && is_normal, normal_shown, "normal shown wrongly")

  // Any raised level carries a reason.
  `DSLA_ASSERT_SAME(a_raised_reason, out_valid && !is_normal, has_reason, "no reason given")

  // Lamp intensities follow the colour code.
  `DSLA_ASSERT_SAME(a_lamp_rgb, out_valid, rgb_ok, "lamp intensities do not match colour")

endmodule

bind dual_sensor_level_alarm_with_blink_unit dsla_port_props u_dsla_port_props (.*);
